// ===== rtl/optical_flow_frame_parser_assert.svh =====
// assertion macros for the optical flow frame parser
// expects clk_i and rst_ni in the scope of the module that includes it
`ifndef OPTICAL_FLOW_FRAME_PARSER_ASSERT_SVH
`define OPTICAL_FLOW_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define OFP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// next-cycle implication, ignored while in reset
`define OFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

// ===== rtl/ofp_pkg.sv =====
// shared types and constants of the optical flow frame parser
// no dependencies
package ofp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned PayloadLen = 10;
  localparam int unsigned PosW       = 4;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [PosW-1:0]  pos_t;

  localparam byte_t HdrFirst  = 8'hFE;
  localparam byte_t HdrSecond = 8'h0A;
  localparam byte_t TailMark  = 8'h55;

  localparam pos_t PosHdr0  = 4'd0;
  localparam pos_t PosHdr1  = 4'd1;
  localparam pos_t PosPay0  = 4'd2;
  localparam pos_t PosCheck = 4'd12;
  localparam pos_t PosTail  = 4'd13;

  // sequencer to datapath
  typedef struct packed {
    logic shift;
    logic emit;
    pos_t pos;
  } ctrl_t;

endpackage

// ===== rtl/optical_flow_frame_parser.sv =====
// optical flow frame parser: takes one received byte per transaction, checks
// 14-byte frames (header FE 0A, ten payload bytes, xor check byte, tail 55) and
// gives one result per good frame. One valid byte is taken every clock cycle unless stalled; the
// payload bytes move down a chain of ten byte cells as they arrive, and the
// running xor and position counter update in the same cycle. A result sits in
// an output register while the next frame's bytes keep flowing in; input is
// stalled only on a tail byte while an earlier result is still held back.
// depends on ofp_pkg, ofp_cell, ofp_seq and optical_flow_frame_parser_assert.svh
module optical_flow_frame_parser
  import ofp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] flow_x_o,
  output logic signed [15:0] flow_y_o,
  output logic [15:0]        time_span_o,
  output logic [15:0]        distance_o,
  output logic [7:0]         quality_o,
  output logic [7:0]         fw_version_o
);

  ctrl_t ctrl;
  logic  fire;
  byte_t chain [PayloadLen+1];

  logic  out_valid_q, out_valid_d;
  logic [15:0] flow_x_q, flow_y_q, time_span_q, distance_q;
  byte_t quality_q, fw_version_q;

  assign in_stall_o = out_valid_q && out_stall_i && (ctrl.pos == PosTail);
  assign fire       = in_valid_i && !in_stall_o;

  ofp_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (rx_byte_i),
    .ctrl_o (ctrl)
  );

  // newest byte enters at the top, after ten shifts cell k holds payload byte k
  assign chain[PayloadLen] = rx_byte_i;

  for (genvar k = 0; k < PayloadLen; k++) begin : g_cell
    ofp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl.shift),
      .data_i  (chain[k+1]),
      .data_o  (chain[k])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      flow_x_q     <= {chain[1], chain[0]};
      flow_y_q     <= {chain[3], chain[2]};
      time_span_q  <= {chain[5], chain[4]};
      distance_q   <= {chain[7], chain[6]};
      quality_q    <= chain[8];
      fw_version_q <= chain[9];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign flow_x_o     = signed'(flow_x_q);
  assign flow_y_o     = signed'(flow_y_q);
  assign time_span_o  = time_span_q;
  assign distance_o   = distance_q;
  assign quality_o    = quality_q;
  assign fw_version_o = fw_version_q;

  `include "optical_flow_frame_parser_assert.svh"

  // a result is never made while the previous one is still held back
  `OFP_ASSERT_IMPLY(a_no_overwrite, ctrl.emit, !(out_valid_q && out_stall_i))
  // a result shows on the output the cycle after it is made
  `OFP_ASSERT_NEXT(a_emit_shows, ctrl.emit, out_valid_o)
  // input only stalls behind a held result
  `OFP_ASSERT_IMPLY(a_stall_cause, in_stall_o, out_valid_q && out_stall_i)
  // the frame position never leaves the frame
  `OFP_ASSERT_IMPLY(a_pos_range, 1'b1, ctrl.pos <= PosTail)

endmodule

// ===== rtl/ofp_cell.sv =====
// one byte cell of the payload chain
// depends on ofp_pkg
module ofp_cell
  import ofp_pkg::*;
(
  input  logic  clk_i,
  input  logic  shift_i,
  input  byte_t data_i,
  output byte_t data_o
);

  byte_t data_q, data_d;

  assign data_d = shift_i ? data_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/ofp_seq.sv =====
// frame position sequencer with running xor and check byte
// depends on ofp_pkg
module ofp_seq
  import ofp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  byte_t byte_i,
  output ctrl_t ctrl_o
);

  pos_t  pos_q, pos_d;
  byte_t xor_q, xor_d;
  byte_t chk_q, chk_d;
  logic  shift, emit;

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    chk_d = chk_q;
    shift = 1'b0;
    emit  = 1'b0;
    if (fire_i) begin
      priority if (pos_q == PosHdr0) begin
        pos_d = (byte_i == HdrFirst) ? PosHdr1 : PosHdr0;
      end else if (pos_q == PosHdr1) begin
        if (byte_i == HdrSecond) begin
          xor_d = '0;
          pos_d = PosPay0;
        end else begin
          // a stray first header byte restarts the header
          pos_d = (byte_i == HdrFirst) ? PosHdr1 : PosHdr0;
        end
      end else if (pos_q < PosCheck) begin
        shift = 1'b1;
        xor_d = xor_q ^ byte_i;
        pos_d = pos_q + pos_t'(1);
      end else if (pos_q == PosCheck) begin
        chk_d = byte_i;
        pos_d = PosTail;
      end else begin
        pos_d = PosHdr0;
        emit  = (pos_q == PosTail) && (byte_i == TailMark) && (xor_q == chk_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHdr0;
      xor_q <= '0;
    end else begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_q <= chk_d;
  end

  assign ctrl_o.shift = shift;
  assign ctrl_o.emit  = emit;
  assign ctrl_o.pos   = pos_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for optical_flow_frame_parser: byte streams of good, broken
// and noisy frames against a frame scoreboard; depends on ofp_pkg and the rtl top
module tb_top;
  import ofp_pkg::*;

  localparam int unsigned ByteTarget  = 500;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic [15:0]        time_span;
    logic [15:0]        distance;
    logic [7:0]         quality;
    logic [7:0]         fw_version;
  } flow_result_t;

  typedef byte_t payload_t [PayloadLen];

  class flow_frame_scoreboard;
    pos_t         frame_pos;
    byte_t        payload_bytes [PayloadLen];
    byte_t        xor_acc;
    byte_t        check_val;
    flow_result_t pending_frames[$];
    int unsigned  n_bytes;
    int unsigned  n_expected;
    int unsigned  n_checked;
    int unsigned  n_errors;

    function new();
      frame_pos  = PosHdr0;
      xor_acc    = '0;
      check_val  = '0;
      n_bytes    = 0;
      n_expected = 0;
      n_checked  = 0;
      n_errors   = 0;
    endfunction

    // follows the frame position and predicts a result on a good tail
    function void take_byte(byte_t b);
      flow_result_t r;
      n_bytes++;
      if (frame_pos == PosHdr0) begin
        frame_pos = (b == HdrFirst) ? PosHdr1 : PosHdr0;
      end else if (frame_pos == PosHdr1) begin
        if (b == HdrSecond) begin
          xor_acc   = '0;
          frame_pos = PosPay0;
        end else begin
          frame_pos = (b == HdrFirst) ? PosHdr1 : PosHdr0;
        end
      end else if (frame_pos < PosCheck) begin
        payload_bytes[frame_pos - PosPay0] = b;
        xor_acc   = xor_acc ^ b;
        frame_pos = frame_pos + pos_t'(1);
      end else if (frame_pos == PosCheck) begin
        check_val = b;
        frame_pos = PosTail;
      end else begin
        if (frame_pos == PosTail && b == TailMark && xor_acc == check_val) begin
          r.flow_x     = {payload_bytes[1], payload_bytes[0]};
          r.flow_y     = {payload_bytes[3], payload_bytes[2]};
          r.time_span  = {payload_bytes[5], payload_bytes[4]};
          r.distance   = {payload_bytes[7], payload_bytes[6]};
          r.quality    = payload_bytes[8];
          r.fw_version = payload_bytes[9];
          pending_frames.push_back(r);
          n_expected++;
        end
        frame_pos = PosHdr0;
      end
    endfunction

    function void check_frame(flow_result_t got);
      flow_result_t exp;
      if (pending_frames.size() == 0) begin
        $error("result with no frame pending: flow_x %0d flow_y %0d", got.flow_x, got.flow_y);
        n_errors++;
        return;
      end
      exp = pending_frames.pop_front();
      n_checked++;
      if (got.flow_x !== exp.flow_x) begin
        $error("flow_x: expected %0d, got %0d", exp.flow_x, got.flow_x);
        n_errors++;
      end
      if (got.flow_y !== exp.flow_y) begin
        $error("flow_y: expected %0d, got %0d", exp.flow_y, got.flow_y);
        n_errors++;
      end
      if (got.time_span !== exp.time_span) begin
        $error("time_span: expected %0d, got %0d", exp.time_span, got.time_span);
        n_errors++;
      end
      if (got.distance !== exp.distance) begin
        $error("distance: expected %0d, got %0d", exp.distance, got.distance);
        n_errors++;
      end
      if (got.quality !== exp.quality) begin
        $error("quality: expected %0d, got %0d", exp.quality, got.quality);
        n_errors++;
      end
      if (got.fw_version !== exp.fw_version) begin
        $error("fw_version: expected %0d, got %0d", exp.fw_version, got.fw_version);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] flow_x_o;
  logic signed [15:0] flow_y_o;
  logic [15:0]        time_span_o;
  logic [15:0]        distance_o;
  logic [7:0]         quality_o;
  logic [7:0]         fw_version_o;

  flow_frame_scoreboard sb;
  int unsigned          burst_left;
  int unsigned          stall_run;
  int unsigned          stall_mode;
  int unsigned          cycle_count;

  optical_flow_frame_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flow_x_o    (flow_x_o),
    .flow_y_o    (flow_y_o),
    .time_span_o (time_span_o),
    .distance_o  (distance_o),
    .quality_o   (quality_o),
    .fw_version_o(fw_version_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stall pattern: runs of no stall, light, heavy and alternating
  always @(negedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(5, 80);
    end
    stall_run--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ~out_stall_i;
    endcase
  end

  always @(posedge clk_i) begin
    flow_result_t got;
    if (rst_ni) begin
      // input first so a same-edge result finds its expectation
      if (in_valid_i && !in_stall_o) sb.take_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        got.flow_x     = flow_x_o;
        got.flow_y     = flow_y_o;
        got.time_span  = time_span_o;
        got.distance   = distance_o;
        got.quality    = quality_o;
        got.fw_version = fw_version_o;
        sb.check_frame(got);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d frames outstanding", cycle_count,
               sb.pending_frames.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one transaction; the sender may pause between bursts of random length
  task automatic send_byte(input byte_t b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        rx_byte_i  <= 8'($urandom_range(0, 255));
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input payload_t pl, input bit bad_sum, input bit bad_tail);
    byte_t sum;
    byte_t tail;
    sum = '0;
    foreach (pl[i]) sum = sum ^ pl[i];
    if (bad_sum) sum = sum ^ byte_t'($urandom_range(1, 255));
    tail = TailMark;
    if (bad_tail) begin
      do tail = byte_t'($urandom_range(0, 255)); while (tail == TailMark);
    end
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(sum);
    send_byte(tail);
  endtask

  // payload bytes lean towards the 16-bit sign and range boundaries
  function automatic byte_t pick_payload_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    payload_t pl;
    int unsigned kind;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_stall_i = 1'b0;
    rx_byte_i   = '0;
    burst_left  = 0;
    stall_run   = 0;
    cycle_count = 0;
    sb = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // junk before a header, wrong second byte, then a repeated first header byte
    send_byte(8'h00);
    send_byte(HdrFirst);
    send_byte(8'h0B);
    send_byte(HdrFirst);
    // good frame: flow_x -32768, flow_y 32767, zero and full-scale fields
    pl = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF};
    send_frame(pl, 1'b0, 1'b0);
    // same payload with a corrupted check byte, dropped
    send_frame(pl, 1'b1, 1'b0);

    while (sb.n_bytes < ByteTarget) begin
      kind = $urandom_range(0, 9);
      foreach (pl[i]) pl[i] = pick_payload_byte();
      if (kind <= 5) begin
        send_frame(pl, 1'b0, 1'b0);
      end else if (kind == 6) begin
        send_frame(pl, 1'b1, 1'b0);
      end else if (kind == 7) begin
        send_frame(pl, 1'b0, 1'b1);
      end else begin
        // noise with header and tail values mixed in
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 4))
            0:       send_byte(HdrFirst);
            1:       send_byte(HdrSecond);
            2:       send_byte(TailMark);
            default: send_byte(byte_t'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes of good, bad-checksum, bad-tail and noise frames", sb.n_bytes);
    $display("checked %0d frames, %0d mismatches", sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== optical_flow_frame_parser.f =====
+incdir+rtl
rtl/ofp_pkg.sv
rtl/ofp_cell.sv
rtl/ofp_seq.sv
rtl/optical_flow_frame_parser.sv
sim/tb_top.sv
